[rtl/core/defc_pkg.sv]
`default_nettype none

package defc_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned CoefWidth  = 16;
   localparam int unsigned LimitWidth = 31;
   localparam int unsigned AccWidth   = 50;
   localparam int unsigned RndWidth   = 34;

   localparam logic [CoefWidth-1:0] CoefFastOld = 16'd58982;
   localparam logic [CoefWidth-1:0] CoefFastNew = 16'd6554;
   localparam logic [CoefWidth-1:0] CoefSlowOld = 16'd64881;
   localparam logic [CoefWidth-1:0] CoefSlowNew = 16'd655;

   localparam logic [1:0] CsrErrorLimit         = 2'd0;
   localparam logic [1:0] CsrDeviationThreshold = 2'd1;
   localparam logic [1:0] CsrInverseGain        = 2'd2;

   localparam logic [LimitWidth-1:0] ErrorLimitReset         = 31'd65536;
   localparam logic [LimitWidth-1:0] DeviationThresholdReset = 31'd32768;
   localparam logic [CoefWidth-1:0]  InverseGainReset        = 16'd6554;

   typedef struct packed {
      logic [LimitWidth-1:0] error_limit;
      logic [LimitWidth-1:0] deviation_threshold;
      logic [CoefWidth-1:0]  inverse_gain;
   } cfg_type;

   typedef struct packed {
      logic enable;
      logic clear;
   } mac_ctrl_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_F_OLD = 9'b000000010,
      ST_F_NEW = 9'b000000100,
      ST_S_OLD = 9'b000001000,
      ST_S_NEW = 9'b000010000,
      ST_S_WB  = 9'b000100000,
      ST_CLAMP = 9'b001000000,
      ST_CORR  = 9'b010000000,
      ST_APPLY = 9'b100000000
   } state_type;

   // floor((v + 2^15) / 2^16), arithmetic
   function automatic logic signed [RndWidth-1:0] round_q16(
      input logic signed [AccWidth-1:0] v
   );
      logic signed [AccWidth-1:0] t;
      t = v + 50'sd32768;
      return $signed(t[AccWidth-1:16]);
   endfunction

   function automatic logic signed [DataWidth-1:0] sat32(
      input logic signed [RndWidth-1:0] v
   );
      logic signed [RndWidth-1:0] hi;
      logic signed [RndWidth-1:0] lo;
      hi = 34'sd2147483647;
      lo = -34'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return $signed(v[DataWidth-1:0]);
   endfunction

endpackage

`default_nettype wire

[rtl/core/defc_mac.sv]
`default_nettype none

module defc_mac (
   input  wire logic                                       clock,
   input  wire defc_pkg::mac_ctrl_type                     ctrl,
   input  wire logic signed [defc_pkg::DataWidth-1:0]      operand,
   input  wire logic        [defc_pkg::CoefWidth-1:0]      coef,
   output logic signed      [defc_pkg::AccWidth-1:0]       acc
);

   logic signed [defc_pkg::AccWidth-2:0] prod;
   logic signed [defc_pkg::AccWidth-1:0] acc_ff;
   logic signed [defc_pkg::AccWidth-1:0] acc_in;

   assign prod = 49'(operand) * 49'($signed({1'b0, coef}));

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.enable) begin
         acc_in = (ctrl.clear ? '0 : acc_ff) + 50'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

[rtl/core/defc_csr.sv]
`default_nettype none

module defc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [defc_pkg::LimitWidth-1:0]     csr_wdata,
   output defc_pkg::cfg_type                        cfg
);

   defc_pkg::cfg_type cfg_ff;
   defc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            defc_pkg::CsrErrorLimit: begin
               cfg_in.error_limit = csr_wdata;
            end
            defc_pkg::CsrDeviationThreshold: begin
               cfg_in.deviation_threshold = csr_wdata;
            end
            defc_pkg::CsrInverseGain: begin
               cfg_in.inverse_gain = csr_wdata[defc_pkg::CoefWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_limit         <= defc_pkg::ErrorLimitReset;
         cfg_ff.deviation_threshold <= defc_pkg::DeviationThresholdReset;
         cfg_ff.inverse_gain        <= defc_pkg::InverseGainReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/dual_ema_drift_corrected_filter.sv]
// channel   | ports           | payload (lsb first)
// req       | req_t*          | tdata[31:0] measurement, signed q16.16
// rsp       | rsp_t*          | tdata[31:0] estimate, signed q16.16
// csr       | csr_we/index    | wdata[30:0]; index 0 limit, 1 threshold, 2 gain
//
// one measurement at a time. one shared 32x17 multiply-accumulate does the four
// blend products and the correction product in turn, with sequencer steps for
// write-back and clamp in between and for apply at the end.
// a result stays in the output register until taken; a stalled result holds
// the apply step. synchronous reset clears the averages, state and valid flag.
`default_nettype none

module dual_ema_drift_corrected_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [defc_pkg::DataWidth-1:0]      req_tdata,   // measurement
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [defc_pkg::DataWidth-1:0]           rsp_tdata,   // estimate
   input  wire logic                                csr_we,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [defc_pkg::LimitWidth-1:0]     csr_wdata
);

   defc_pkg::cfg_type      cfg;
   defc_pkg::mac_ctrl_type mac_ctrl;
   defc_pkg::state_type    state_ff, state_in;

   logic signed [defc_pkg::DataWidth-1:0] mac_operand;
   logic        [defc_pkg::CoefWidth-1:0] mac_coef;
   logic signed [defc_pkg::AccWidth-1:0]  acc;

   logic signed [defc_pkg::DataWidth-1:0] meas_ff, meas_in;
   logic signed [defc_pkg::DataWidth-1:0] fast_ff, fast_in;
   logic signed [defc_pkg::DataWidth-1:0] slow_ff, slow_in;
   logic signed [defc_pkg::DataWidth-1:0] diff_ff, diff_in;
   logic                                  trig_ff, trig_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic        [defc_pkg::DataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic signed [defc_pkg::DataWidth-1:0] acc_rounded;
   logic signed [defc_pkg::DataWidth:0]   raw_diff;
   logic signed [defc_pkg::DataWidth-1:0] sat_diff;
   logic signed [defc_pkg::DataWidth:0]   sat_diff_x;
   logic signed [defc_pkg::DataWidth:0]   lim_x;
   logic signed [defc_pkg::DataWidth:0]   clamped;
   logic signed [defc_pkg::DataWidth:0]   diff_x;
   logic signed [defc_pkg::DataWidth:0]   thr_x;
   logic signed [defc_pkg::RndWidth-1:0]  corrected;
   logic signed [defc_pkg::DataWidth-1:0] corrected_sat;
   logic signed [defc_pkg::DataWidth-1:0] result;
   logic                                  out_free;

   defc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   defc_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .operand (mac_operand),
      .coef    (mac_coef),
      .acc     (acc)
   );

   assign req_tready = (state_ff == defc_pkg::ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign acc_rounded = defc_pkg::sat32(defc_pkg::round_q16(acc));

   // slow minus fast, saturated, then clamped to the error limit
   assign raw_diff   = $signed({slow_ff[31], slow_ff}) - $signed({fast_ff[31], fast_ff});
   assign sat_diff   = defc_pkg::sat32($signed({raw_diff[32], raw_diff}));
   assign sat_diff_x = $signed({sat_diff[31], sat_diff});
   assign lim_x      = $signed({2'b00, cfg.error_limit});

   always_comb begin
      clamped = sat_diff_x;
      if (sat_diff_x > lim_x) begin
         clamped = lim_x;
      end else if (sat_diff_x < -lim_x) begin
         clamped = -lim_x;
      end
   end

   assign diff_x = $signed({diff_ff[31], diff_ff});
   assign thr_x  = $signed({2'b00, cfg.deviation_threshold});

   assign corrected = $signed({{2{slow_ff[31]}}, slow_ff}) - defc_pkg::round_q16(acc);
   assign corrected_sat = defc_pkg::sat32(corrected);
   assign result = trig_ff ? corrected_sat : slow_ff;

   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      diff_in      = diff_ff;
      trig_in      = trig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mac_ctrl     = '0;
      mac_operand  = meas_ff;
      mac_coef     = defc_pkg::CoefFastNew;
      case (state_ff)
         defc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               meas_in  = $signed(req_tdata);
               state_in = defc_pkg::ST_F_OLD;
            end
         end
         defc_pkg::ST_F_OLD: begin
            mac_ctrl    = '{enable: 1'b1, clear: 1'b1};
            mac_operand = fast_ff;
            mac_coef    = defc_pkg::CoefFastOld;
            state_in    = defc_pkg::ST_F_NEW;
         end
         defc_pkg::ST_F_NEW: begin
            mac_ctrl    = '{enable: 1'b1, clear: 1'b0};
            mac_operand = meas_ff;
            mac_coef    = defc_pkg::CoefFastNew;
            state_in    = defc_pkg::ST_S_OLD;
         end
         defc_pkg::ST_S_OLD: begin
            fast_in     = acc_rounded;
            mac_ctrl    = '{enable: 1'b1, clear: 1'b1};
            mac_operand = slow_ff;
            mac_coef    = defc_pkg::CoefSlowOld;
            state_in    = defc_pkg::ST_S_NEW;
         end
         defc_pkg::ST_S_NEW: begin
            mac_ctrl    = '{enable: 1'b1, clear: 1'b0};
            mac_operand = meas_ff;
            mac_coef    = defc_pkg::CoefSlowNew;
            state_in    = defc_pkg::ST_S_WB;
         end
         defc_pkg::ST_S_WB: begin
            slow_in  = acc_rounded;
            state_in = defc_pkg::ST_CLAMP;
         end
         defc_pkg::ST_CLAMP: begin
            diff_in  = clamped[defc_pkg::DataWidth-1:0];
            state_in = defc_pkg::ST_CORR;
         end
         defc_pkg::ST_CORR: begin
            mac_ctrl    = '{enable: 1'b1, clear: 1'b1};
            mac_operand = diff_ff;
            mac_coef    = cfg.inverse_gain;
            trig_in     = (diff_x > thr_x) || (diff_x < -thr_x);
            state_in    = defc_pkg::ST_APPLY;
         end
         defc_pkg::ST_APPLY: begin
            if (out_free) begin
               slow_in      = result;
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = defc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = defc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= defc_pkg::ST_IDLE;
         fast_ff      <= '0;
         slow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      diff_ff     <= diff_in;
      trig_ff     <= trig_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/defc_checker.sv]
`default_nettype none

module defc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [defc_pkg::DataWidth-1:0]      rsp_tdata
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // busy for the whole sequence after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready [*8])
      else $error("input ready too soon after accept");

   // a fresh result comes with the input side free again
   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result shown while still busy");

   // nothing pending straight after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state not cleared by reset");

endmodule

bind dual_ema_drift_corrected_filter defc_checker u_defc_checker (.*);

`default_nettype wire
